// ===== rtl/core/ine_pkg.sv =====
package ine_pkg;

  localparam int LINE_MAX = 512;
  localparam int ROWS_MAX = 512;

  localparam int CFG_W   = 10;
  localparam int COL_W   = $clog2(LINE_MAX);
  localparam int LEN_W   = $clog2(LINE_MAX + 1);
  localparam int ROW_W   = $clog2(ROWS_MAX + 1);
  localparam int SMP_W   = 16;
  localparam int ENT_W   = SMP_W + 1;
  localparam int LAP_W   = SMP_W + 5;
  localparam int SQ_W    = 2 * LAP_W;
  localparam int CSUM_W  = 35;
  localparam int SSUM_W  = 64;
  localparam int CNT_W   = 18;
  localparam int DIV_W   = 64;
  localparam int ROOT_W  = DIV_W / 2;
  localparam int SIG_W   = 17;

  localparam logic [0:0] REG_ROW_LENGTH = 1'b0;
  localparam logic [0:0] REG_ROW_COUNT  = 1'b1;

  localparam logic [CFG_W-1:0] ROW_LENGTH_RST = CFG_W'(512);
  localparam logic [CFG_W-1:0] ROW_COUNT_RST  = CFG_W'(512);

  // Division of a 32-bit root by six as a multiply by a scaled reciprocal.
  localparam logic [ROOT_W-1:0] SIX_RECIP = ROOT_W'(32'hAAAA_AAAB);
  localparam int                SIX_SHIFT = 34;

endpackage

// ===== rtl/core/ine_div.sv =====
module ine_div import ine_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  q_r;
  logic [CNT_W-1:0]  d_r;
  logic [CNT_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              fits;

  assign rem_sh  = {rem_r, q_r[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign fits    = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        q_r    <= dividend;
        d_r    <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r  <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        q_r    <= {q_r[DIV_W-2:0], fits};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/core/ine_isqrt.sv =====
module ine_isqrt import ine_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W  = ROOT_W + 4;
  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic [DIV_W-1:0]  x_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  cur;
  logic [REM_W-1:0]  trial;
  logic              fits;

  assign cur   = {rem_r[REM_W-3:0], x_r[DIV_W-1:DIV_W-2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign fits  = cur >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        x_r    <= radicand;
        root_r <= '0;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r  <= fits ? cur - trial : cur;
        root_r <= {root_r[ROOT_W-2:0], fits};
        x_r    <= {x_r[DIV_W-3:0], 2'b00};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/core/image_noise_estimate_3x3.sv =====
// Frame noise estimator over a 3x3 window.
// The input channel (in_valid/in_ready) takes one sample of the image per
// item in raster order, with a valid flag and a frame end marker. For each
// item the line-store read, the window shift, the Laplacian, the squaring
// multiplier and the accumulation run one after another under the
// sequencer, and in_ready is high only while the sequencer is idle.
// On the item that carries frame_end the block works out the result, when
// at least one window was counted, with one shared restoring divider (used
// twice), a digit-by-digit square root unit and a multiply by a scaled
// reciprocal of six; the result item goes out on out_valid/out_ready. The
// result sits in an output register until it is taken; a new frame may
// start meanwhile, and the block waits only if a further result is ready
// while the previous one is still held. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce. Reset clears the
// sequencer, the window, the frame counters and sums, and sets both
// dimensions to 512. The line stores are not cleared; entries read before
// their row is written fall only in windows that are not counted.
module image_noise_estimate_3x3 import ine_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [0:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SMP_W-1:0] in_sample,
  input  logic                    in_sample_valid,
  input  logic                    in_frame_end,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] out_mean_value,
  output logic [SIG_W-1:0]        out_noise_sigma,
  output logic [CNT_W-1:0]        out_window_count,
  output logic                    out_no_windows
);

  typedef enum logic [3:0] {
    S_IDLE, S_WIN, S_LAP, S_SQ, S_ACC, S_FIN, S_MDIV, S_VDIV, S_SQRT, S_OUT
  } state_t;

  state_t state_r;

  logic [CFG_W-1:0] row_length_r;
  logic [CFG_W-1:0] row_count_r;
  logic [LEN_W-1:0] rl;
  logic [ROW_W-1:0] rc;

  logic [ENT_W-1:0] mem_a [LINE_MAX];
  logic [ENT_W-1:0] mem_b [LINE_MAX];
  logic [ENT_W-1:0] top_q_r;
  logic [ENT_W-1:0] mid_q_r;
  logic [ENT_W-1:0] entry_r;
  logic             fe_r;

  logic [ENT_W-1:0] win_r [3][3];
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             inner_r;
  logic             use_r;

  logic signed [LAP_W-1:0]  lap_r;
  logic [SQ_W-1:0]          sq_r;
  logic signed [CSUM_W-1:0] csum_r;
  logic [SSUM_W-1:0]        ssum_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     neg_r;
  logic [SMP_W-1:0]         mean_r;
  logic [SIG_W-1:0]         sig_r;

  logic             div_go_r;
  logic [DIV_W-1:0] div_a_r;
  logic [CNT_W-1:0] div_b_r;
  logic             div_done;
  logic [DIV_W-1:0] div_q;
  logic             sq_go_r;
  logic             sq_done;
  logic [ROOT_W-1:0] sq_root;
  logic [2*ROOT_W-1:0] sig_prod;
  logic             out_load;

  logic signed [LAP_W-1:0] ctr;
  logic signed [LAP_W-1:0] edges;
  logic signed [LAP_W-1:0] corners;
  logic signed [LAP_W-1:0] lap;
  logic signed [SQ_W-1:0]  sq_full;
  logic                    all_valid;
  logic [CSUM_W-1:0]       cmag;
  logic [LEN_W:0]          col_inc;

  always_comb begin
    if (row_length_r == '0) begin
      rl = LEN_W'(1);
    end else if (int'(row_length_r) > LINE_MAX) begin
      rl = LEN_W'(LINE_MAX);
    end else begin
      rl = LEN_W'(row_length_r);
    end
    if (row_count_r == '0) begin
      rc = ROW_W'(1);
    end else if (int'(row_count_r) > ROWS_MAX) begin
      rc = ROW_W'(ROWS_MAX);
    end else begin
      rc = ROW_W'(row_count_r);
    end
  end

  function automatic logic signed [LAP_W-1:0] ev(input logic [ENT_W-1:0] e);
    logic signed [SMP_W-1:0] s;
    s = signed'(e[SMP_W-1:0]);
    return LAP_W'(s);
  endfunction

  always_comb begin
    all_valid = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        all_valid &= win_r[i][j][SMP_W];
      end
    end
    ctr     = ev(win_r[1][1]);
    edges   = ev(win_r[0][1]) + ev(win_r[2][1]) + ev(win_r[1][0]) + ev(win_r[1][2]);
    corners = ev(win_r[0][0]) + ev(win_r[0][2]) + ev(win_r[2][0]) + ev(win_r[2][2]);
    lap     = (ctr <<< 2) - (edges <<< 1) + corners;
  end

  assign sq_full  = lap_r * lap_r;
  assign cmag     = csum_r[CSUM_W-1] ? CSUM_W'(-csum_r) : CSUM_W'(csum_r);
  assign col_inc  = {1'b0, LEN_W'(col_r)} + 1'b1;
  assign sig_prod = sq_root * SIX_RECIP;
  assign out_load = (state_r == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      top_q_r <= mem_b[col_r];
      mid_q_r <= mem_a[col_r];
    end
    if (state_r == S_WIN) begin
      mem_b[col_r] <= mid_q_r;
      mem_a[col_r] <= entry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_length_r <= ROW_LENGTH_RST;
      row_count_r  <= ROW_COUNT_RST;
      col_r        <= '0;
      row_r        <= '0;
      csum_r       <= '0;
      ssum_r       <= '0;
      cnt_r        <= '0;
      out_valid    <= 1'b0;
      div_go_r     <= 1'b0;
      sq_go_r      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      div_go_r <= 1'b0;
      sq_go_r  <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROW_LENGTH: row_length_r <= cfg_data;
          REG_ROW_COUNT:  row_count_r  <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            entry_r <= {in_sample_valid, in_sample};
            fe_r    <= in_frame_end;
            state_r <= S_WIN;
          end
        end
        S_WIN: begin
          for (int k = 0; k < 3; k++) begin
            win_r[k][0] <= win_r[k][1];
            win_r[k][1] <= win_r[k][2];
          end
          win_r[0][2] <= top_q_r;
          win_r[1][2] <= mid_q_r;
          win_r[2][2] <= entry_r;
          inner_r <= (row_r >= ROW_W'(2)) && (row_r < rc) &&
                     (LEN_W'(col_r) >= LEN_W'(2)) && (LEN_W'(col_r) < rl);
          state_r <= S_LAP;
        end
        S_LAP: begin
          lap_r   <= lap;
          use_r   <= inner_r && all_valid;
          state_r <= S_SQ;
        end
        S_SQ: begin
          sq_r    <= SQ_W'(sq_full);
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (use_r) begin
            csum_r <= csum_r + CSUM_W'(ctr);
            ssum_r <= ssum_r + SSUM_W'(sq_r);
            cnt_r  <= cnt_r + 1'b1;
          end
          if (fe_r) begin
            state_r <= S_FIN;
          end else begin
            if (col_inc >= {1'b0, rl}) begin
              col_r <= '0;
              if (row_r < rc) begin
                row_r <= row_r + 1'b1;
              end
            end else begin
              col_r <= COL_W'(col_inc);
            end
            state_r <= S_IDLE;
          end
        end
        S_FIN: begin
          neg_r <= csum_r[CSUM_W-1];
          if (cnt_r == '0) begin
            state_r <= S_OUT;
          end else begin
            div_a_r  <= DIV_W'(cmag);
            div_b_r  <= cnt_r;
            div_go_r <= 1'b1;
            state_r  <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (div_done) begin
            mean_r   <= neg_r ? SMP_W'(-div_q[SMP_W-1:0]) : div_q[SMP_W-1:0];
            div_a_r  <= ssum_r;
            div_go_r <= 1'b1;
            state_r  <= S_VDIV;
          end
        end
        S_VDIV: begin
          if (div_done) begin
            sq_go_r <= 1'b1;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            sig_r   <= SIG_W'(sig_prod >> SIX_SHIFT);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid        <= 1'b1;
            out_window_count <= cnt_r;
            out_no_windows   <= (cnt_r == '0);
            out_mean_value   <= (cnt_r == '0) ? '0 : signed'(mean_r);
            out_noise_sigma  <= (cnt_r == '0) ? '0 : sig_r;
            col_r   <= '0;
            row_r   <= '0;
            csum_r  <= '0;
            ssum_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);

  ine_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quotient (div_q)
  );

  ine_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_go_r),
    .radicand (div_q),
    .done     (sq_done),
    .root     (sq_root)
  );

endmodule
